[src/assert_macros.svh]
// Assertion macros used by the top level of the semaphore table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Property checked on every rising clk_i edge outside reset.
`define CST_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Condition that must never hold outside reset.
`define CST_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define CST_ASSERT(name, prop, msg)
`define CST_NEVER(name, cond, msg)
`endif

`endif

[src/cst_pkg.sv]
// Package with the types, codes and helper functions of the semaphore table.
`default_nettype none

package cst_pkg;

  localparam int unsigned NUM_SEMS    = 32;
  localparam int unsigned COUNT_WIDTH = 16;
  localparam int unsigned IDX_W       = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;

  // Fixed widths of the stream fields.
  localparam int unsigned OP_W     = 2;
  localparam int unsigned SEM_W    = 6;
  localparam int unsigned INIT_W   = 16;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned IN_W     = 24;
  localparam int unsigned OUT_W    = 32;

  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [IDX_W-1:0]       idx_t;

  localparam count_t COUNT_MAX = '1;

  typedef enum logic [OP_W-1:0] {
    OP_CREATE = 2'd0,
    OP_FREE   = 2'd1,
    OP_WAIT   = 2'd2,
    OP_SIGNAL = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 3'd0,
    ST_FULL        = 3'd1,
    ST_BAD_INDEX   = 3'd2,
    ST_NOT_IN_USE  = 3'd3,
    ST_WOULD_BLOCK = 3'd4,
    ST_SATURATED   = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  // Update request for the in-use flags.
  typedef struct packed {
    logic set;
    logic clr;
    idx_t idx;
  } flag_upd_t;

  // Lowest free entry, as found by the priority encoder.
  typedef struct packed {
    logic found;
    idx_t idx;
  } alloc_t;

  // Clamp a create count to the range of the stored count.
  function automatic count_t sat_init(input logic [INIT_W-1:0] v);
    logic [31:0] w;
    logic [31:0] m;
    w = 32'(v);
    m = 32'(COUNT_MAX);
    return (w > m) ? COUNT_MAX : count_t'(w);
  endfunction

  // Low bits of a count as reported on the output stream.
  function automatic logic [INIT_W-1:0] count_out(input count_t c);
    logic [31:0] w;
    w = 32'(c);
    return w[INIT_W-1:0];
  endfunction

endpackage

`default_nettype wire

[src/cst_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none

module cst_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[src/cst_flags.sv]
// In-use flags of all entries and the lowest-free-entry priority encoder.
`default_nettype none

module cst_flags (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire cst_pkg::flag_upd_t            upd_i,
  output logic [cst_pkg::NUM_SEMS-1:0]       flags_o,
  output cst_pkg::alloc_t                    alloc_o
);
  import cst_pkg::*;

  logic [NUM_SEMS-1:0] flags_q;
  logic [NUM_SEMS-1:0] flags_d;

  always_comb begin
    flags_d = flags_q;
    if (upd_i.set) begin
      flags_d[upd_i.idx] = 1'b1;
    end else if (upd_i.clr) begin
      flags_d[upd_i.idx] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else begin
      flags_q <= flags_d;
    end
  end

  // Scanning from the top down leaves the lowest free entry as the winner.
  always_comb begin
    alloc_o.found = 1'b0;
    alloc_o.idx   = '0;
    for (int i = NUM_SEMS - 1; i >= 0; i--) begin
      if (!flags_q[i]) begin
        alloc_o.found = 1'b1;
        alloc_o.idx   = idx_t'(i);
      end
    end
  end

  assign flags_o = flags_q;

endmodule

`default_nettype wire

[src/counting_semaphore_table_core.sv]
// Top level of the counting semaphore table: control, count memory and output register.
`default_nettype none
`include "assert_macros.svh"

// Table of NUM_SEMS counting semaphores, driven by a stream of operations
// (create, free, wait, signal), each of which produces exactly one result
// transfer. The in-use flags sit in flip-flops that reset clears, so the
// table is usable straight after reset without any clearing pass; the
// counts live in a synchronous RAM whose read data is used only for entries
// whose flag is set, so its contents after reset never matter. Each
// operation passes through S_IDLE, which accepts the transfer, finds the
// lowest free entry and issues the count read, and then S_EXEC, which
// evaluates and writes back the entry. The registered read of the count RAM
// is why evaluation waits for S_EXEC, and one operation is in flight at a
// time, so accesses to the same entry can never overlap. A finished result
// waits in an output register; when the downstream side holds it, the
// operation after it stalls in S_EXEC until that register drains.
module counting_semaphore_table_core (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // Fields from bit 0 up: operation[1:0], sem_index[7:2], initial_count[23:8].
  input  wire logic [cst_pkg::IN_W-1:0]     s_axis_tdata,
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  // Fields from bit 0 up: status[2:0], granted_index[8:3], count_after[24:9],
  // then zero fill.
  output logic [cst_pkg::OUT_W-1:0]         m_axis_tdata,
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready
);
  import cst_pkg::*;

  state_e state_q, state_d;

  // Operation captured at acceptance.
  op_e               op_q;
  logic [SEM_W-1:0]  sem_q;
  logic [INIT_W-1:0] init_q;
  alloc_t            alloc_q;

  // Output register.
  logic                out_valid_q, out_valid_d;
  logic [OUT_W-1:0]    out_data_q,  out_data_d;

  logic [NUM_SEMS-1:0] flags;
  alloc_t              alloc;
  flag_upd_t           flag_upd;

  logic   in_xfer;
  logic   commit;
  logic   ram_we;
  idx_t   ram_waddr;
  count_t ram_wdata;
  count_t ram_rdata;
  idx_t   entry;
  logic   bad_index;
  logic   entry_used;

  status_e           res_status;
  logic [SEM_W-1:0]  res_index;
  count_t            res_count;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  // The execute state completes once the output register has room.
  assign commit = (state_q == S_EXEC) && (!out_valid_q || m_axis_tready);

  cst_flags u_flags (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .upd_i   (flag_upd),
    .flags_o (flags),
    .alloc_o (alloc)
  );

  cst_ram #(
    .Width (COUNT_WIDTH),
    .Depth (NUM_SEMS)
  ) u_count_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (in_xfer),
    .raddr_i (s_axis_tdata[OP_W+IDX_W-1:OP_W]),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q    <= op_e'(s_axis_tdata[OP_W-1:0]);
      sem_q   <= s_axis_tdata[OP_W+SEM_W-1:OP_W];
      init_q  <= s_axis_tdata[IN_W-1:OP_W+SEM_W];
      alloc_q <= alloc;
    end
  end

  assign entry      = sem_q[IDX_W-1:0];
  assign bad_index  = ({1'b0, sem_q} >= (SEM_W+1)'(NUM_SEMS));
  assign entry_used = flags[entry];

  // Evaluate the operation against the entry that was read at acceptance.
  always_comb begin
    res_status = ST_OK;
    res_index  = '0;
    res_count  = '0;
    ram_we     = 1'b0;
    ram_waddr  = entry;
    ram_wdata  = '0;
    flag_upd   = '{set: 1'b0, clr: 1'b0, idx: entry};

    case (op_q)
      OP_CREATE: begin
        if (alloc_q.found) begin
          res_index    = SEM_W'(alloc_q.idx);
          res_count    = sat_init(init_q);
          ram_we       = commit;
          ram_waddr    = alloc_q.idx;
          ram_wdata    = res_count;
          flag_upd.set = commit;
          flag_upd.idx = alloc_q.idx;
        end else begin
          res_status = ST_FULL;
        end
      end
      OP_FREE: begin
        if (bad_index) begin
          res_status = ST_BAD_INDEX;
        end else begin
          // The count of a free entry is never used, so only the flag clears.
          flag_upd.clr = commit;
        end
      end
      OP_WAIT: begin
        if (bad_index) begin
          res_status = ST_BAD_INDEX;
        end else if (!entry_used) begin
          res_status = ST_NOT_IN_USE;
        end else if (ram_rdata == '0) begin
          res_status = ST_WOULD_BLOCK;
        end else begin
          res_count = ram_rdata - count_t'(1);
          ram_we    = commit;
          ram_wdata = res_count;
        end
      end
      OP_SIGNAL: begin
        if (bad_index) begin
          res_status = ST_BAD_INDEX;
        end else if (!entry_used) begin
          res_status = ST_NOT_IN_USE;
        end else if (ram_rdata == COUNT_MAX) begin
          res_status = ST_SATURATED;
          res_count  = COUNT_MAX;
        end else begin
          res_count = ram_rdata + count_t'(1);
          ram_we    = commit;
          ram_wdata = res_count;
        end
      end
      default: begin
        res_status = ST_OK;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (commit) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (commit) begin
      out_valid_d = 1'b1;
      out_data_d  = {(OUT_W-STATUS_W-SEM_W-INIT_W)'(0), count_out(res_count), res_index,
                     res_status};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  `CST_ASSERT(a_accept_then_exec, in_xfer |=> (state_q == S_EXEC), "accepted item did not move to the execute cycle")
  `CST_NEVER(a_ram_write_idle, ram_we && !commit, "count written outside a committed operation")
  `CST_ASSERT(a_create_sets_flag, (commit && op_q == OP_CREATE && alloc_q.found) |=> flags[$past(alloc_q.idx)], "created entry is not marked in use")
  `CST_ASSERT(a_commit_fills_out, commit |=> m_axis_tvalid, "committed result did not reach the output register")
  `CST_NEVER(a_flag_set_and_clr, flag_upd.set && flag_upd.clr, "flag set and clear requested together")

endmodule

`default_nettype wire
